>>> hw/rtl/tppu_pkg.sv
// ----------------------------------------------------------------------------
// tppu_pkg: shared types and widths of the terrain projection unit
// Fixed widths of the rotation datapath, the multiply/divide lanes and the
// register map.
// ----------------------------------------------------------------------------
package tppu_pkg;

  localparam int unsigned DXW = 33;  // point minus observer
  localparam int unsigned MW  = 19;  // derived matrix entries, Q14
  localparam int unsigned TZW = 43;  // scaled height plus offset
  localparam int unsigned ZW  = 62;  // rotated u, v, z in Q22
  localparam int unsigned AW  = 61;  // magnitudes of u, v, z
  localparam int unsigned PW  = 93;  // magnitude times focal scale
  localparam int unsigned QW  = 40;  // quotient bits below the cap

  typedef enum logic [2:0] {
    CFG_COS_YAW       = 3'd0,
    CFG_SIN_YAW       = 3'd1,
    CFG_COS_PITCH     = 3'd2,
    CFG_SIN_PITCH     = 3'd3,
    CFG_OBSERVER_X    = 3'd4,
    CFG_OBSERVER_Y    = 3'd5,
    CFG_HEIGHT_OFFSET = 3'd6,
    CFG_FOCAL_SCALE   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0]   cy;
    logic signed [15:0]   sy;
    logic signed [15:0]   cp;
    logic signed [15:0]   sp;
    logic signed [MW-1:0] m10;
    logic signed [MW-1:0] m11;
    logic signed [MW-1:0] m20;
    logic signed [MW-1:0] m21;
    logic signed [31:0]   ox;
    logic signed [31:0]   oy;
    logic signed [31:0]   hoff;
  } rot_cfg_t;

  // Flags that ride along with the division lanes
  typedef struct packed {
    logic vis;
    logic neg_col;
    logic neg_row;
  } side_t;

endpackage

>>> hw/rtl/terrain_perspective_projection_unit.sv
// ----------------------------------------------------------------------------
// terrain_perspective_projection_unit: pinhole projection of terrain points
// Streams terrain points in, image column/row and a visible flag out.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | tdata: point_x, point_y, terrain_height; tuser: valid
//  m_axis   | out       | tdata: pixel_col, pixel_row; tuser: visible
//  cfg      | in        | cfg_we_i / cfg_idx_i / cfg_data_i, write only
//
//  One point per cycle sustained while results are taken; from input transfer to
//  result: 4 rotation stages, 1 depth test stage, 2 multiply stages, a cap
//  check, 40 stages of the bit-per-stage divider and the output register.
//  Reset clears the valid bits and loads the register reset values.
//  The whole pipeline advances when the output register is empty or its
//  result is taken; a held result freezes every stage, so nothing is lost.
//
module terrain_perspective_projection_unit
  import tppu_pkg::*;
#(
  parameter int unsigned IMAGE_ROWS      = 512,
  parameter int unsigned IMAGE_COLS      = 512,
  parameter int unsigned HEIGHT_SCALE_Q8 = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // point_x[31:0], point_y[63:32], terrain_height[95:64]
  input  logic [0:0]  s_axis_tuser,   // height_valid[0]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // pixel_col[31:0], pixel_row[63:32]
  output logic [0:0]  m_axis_tuser,   // visible[0]
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic signed [43:0] CenterCol = 44'(IMAGE_COLS) <<< 7;
  localparam logic signed [43:0] CenterRow = 44'(IMAGE_ROWS) <<< 7;
  localparam logic signed [43:0] SatMax    = 44'sh0007FFFFFFF;
  localparam logic signed [43:0] SatMin    = -44'sh00080000000;
  localparam logic signed [ZW-1:0] ZNear   = -(ZW'(1) <<< 22);

  // Configuration registers
  logic signed [15:0] cos_yaw_q, sin_yaw_q, cos_pitch_q, sin_pitch_q;
  logic signed [31:0] observer_x_q, observer_y_q, height_offset_q;
  logic [31:0]        focal_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_yaw_q       <= 16'sd16384;
      sin_yaw_q       <= '0;
      cos_pitch_q     <= 16'sd16384;
      sin_pitch_q     <= '0;
      observer_x_q    <= '0;
      observer_y_q    <= '0;
      height_offset_q <= '0;
      focal_scale_q   <= 32'd91776;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COS_YAW:       cos_yaw_q       <= cfg_data_i[15:0];
        CFG_SIN_YAW:       sin_yaw_q       <= cfg_data_i[15:0];
        CFG_COS_PITCH:     cos_pitch_q     <= cfg_data_i[15:0];
        CFG_SIN_PITCH:     sin_pitch_q     <= cfg_data_i[15:0];
        CFG_OBSERVER_X:    observer_x_q    <= cfg_data_i;
        CFG_OBSERVER_Y:    observer_y_q    <= cfg_data_i;
        CFG_HEIGHT_OFFSET: height_offset_q <= cfg_data_i;
        CFG_FOCAL_SCALE:   focal_scale_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pitch-times-yaw entries, floored to Q14; refreshed every cycle so a new
  // setting is in place by the time the first product stage uses it
  logic signed [32:0] cpsy, cpcy, spsy, spcy;
  logic signed [MW-1:0] m10_q, m11_q, m20_q, m21_q;

  assign cpsy = 33'(cos_pitch_q * sin_yaw_q);
  assign cpcy = 33'(cos_pitch_q * cos_yaw_q);
  assign spsy = 33'(sin_pitch_q * sin_yaw_q);
  assign spcy = 33'(sin_pitch_q * cos_yaw_q);

  always_ff @(posedge clk_i) begin
    m10_q <= MW'((-cpsy) >>> 14);
    m11_q <= MW'(cpcy >>> 14);
    m20_q <= MW'(spsy >>> 14);
    m21_q <= MW'((-spcy) >>> 14);
  end

  rot_cfg_t rot_cfg;
  always_comb begin
    rot_cfg.cy   = cos_yaw_q;
    rot_cfg.sy   = sin_yaw_q;
    rot_cfg.cp   = cos_pitch_q;
    rot_cfg.sp   = sin_pitch_q;
    rot_cfg.m10  = m10_q;
    rot_cfg.m11  = m11_q;
    rot_cfg.m20  = m20_q;
    rot_cfg.m21  = m21_q;
    rot_cfg.ox   = observer_x_q;
    rot_cfg.oy   = observer_y_q;
    rot_cfg.hoff = height_offset_q;
  end

  // Advance everything unless a result sits in the output register untaken
  logic en;
  logic out_valid_q;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  logic                 rot_valid, rot_hv;
  logic signed [ZW-1:0] rot_u, rot_v, rot_z;

  tppu_rotate #(
    .HEIGHT_SCALE_Q8(HEIGHT_SCALE_Q8)
  ) u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .px_i    (s_axis_tdata[31:0]),
    .py_i    (s_axis_tdata[63:32]),
    .h_i     (s_axis_tdata[95:64]),
    .hv_i    (s_axis_tuser[0]),
    .cfg_i   (rot_cfg),
    .valid_o (rot_valid),
    .hv_o    (rot_hv),
    .u_o     (rot_u),
    .v_o     (rot_v),
    .z_o     (rot_z)
  );

  // Depth test and magnitudes; the quotient sign is applied at the end
  logic          dep_valid_q;
  side_t         dep_side_q;
  logic [AW-1:0] au_q, av_q, az_q;
  logic signed [ZW-1:0] nu, nv, nz;

  assign nu = -rot_u;
  assign nv = -rot_v;
  assign nz = -rot_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dep_valid_q <= 1'b0;
    end else if (en) begin
      dep_valid_q <= rot_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dep_side_q.vis     <= rot_hv && (rot_z <= ZNear);
      dep_side_q.neg_col <= rot_u[ZW-1];
      dep_side_q.neg_row <= !rot_v[ZW-1] && (rot_v != '0);
      au_q <= rot_u[ZW-1] ? nu[AW-1:0] : rot_u[AW-1:0];
      av_q <= rot_v[ZW-1] ? nv[AW-1:0] : rot_v[AW-1:0];
      az_q <= nz[AW-1:0];
    end
  end

  logic          md_valid;
  side_t         md_side;
  logic [QW:0]   q_col, q_row;

  tppu_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dep_valid_q),
    .side_i  (dep_side_q),
    .a_col_i (au_q),
    .a_row_i (av_q),
    .d_i     (az_q),
    .sf_i    (focal_scale_q),
    .valid_o (md_valid),
    .side_o  (md_side),
    .q_col_o (q_col),
    .q_row_o (q_row)
  );

  // Sign, center and saturate
  logic signed [43:0] col_sum, row_sum;
  logic signed [43:0] qc_s, qr_s;
  logic signed [31:0] col_d, row_d;

  assign qc_s    = $signed({3'b0, q_col});
  assign qr_s    = $signed({3'b0, q_row});
  assign col_sum = (md_side.neg_col ? -qc_s : qc_s) + CenterCol;
  assign row_sum = (md_side.neg_row ? -qr_s : qr_s) + CenterRow;

  always_comb begin
    if (!md_side.vis) begin
      col_d = '0;
      row_d = '0;
    end else begin
      if (col_sum > SatMax) begin
        col_d = 32'sh7FFFFFFF;
      end else if (col_sum < SatMin) begin
        col_d = 32'sh80000000;
      end else begin
        col_d = col_sum[31:0];
      end
      if (row_sum > SatMax) begin
        row_d = 32'sh7FFFFFFF;
      end else if (row_sum < SatMin) begin
        row_d = 32'sh80000000;
      end else begin
        row_d = row_sum[31:0];
      end
    end
  end

  // Output register: load on every advance, hold while the result waits
  logic [63:0] out_data_q;
  logic        out_vis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= md_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {row_d, col_d};
      out_vis_q  <= md_side.vis;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_vis_q;

endmodule

>>> hw/rtl/tppu_rotate.sv
// ----------------------------------------------------------------------------
// tppu_rotate: translate, scale height and rotate one point per cycle while en_i is high
// Four register stages: offsets, products, partial sums, final sums.
// ----------------------------------------------------------------------------
module tppu_rotate
  import tppu_pkg::*;
#(
  parameter int unsigned HEIGHT_SCALE_Q8 = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [31:0]   px_i,
  input  logic signed [31:0]   py_i,
  input  logic signed [31:0]   h_i,
  input  logic                 hv_i,
  input  rot_cfg_t             cfg_i,
  output logic                 valid_o,
  output logic                 hv_o,
  output logic signed [ZW-1:0] u_o,
  output logic signed [ZW-1:0] v_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [17:0] HScale = 18'(HEIGHT_SCALE_Q8);

  logic [3:0] vld_q;
  logic [2:0] hv_q;

  logic signed [DXW-1:0] dx_q, dy_q;
  logic signed [49:0]    hprod_q;

  logic signed [TZW-1:0] tz_q;
  logic signed [48:0]    pu0_q, pu1_q;
  logic signed [51:0]    pv0_q, pv1_q, pz0_q, pz1_q;

  logic signed [58:0]    pv2_q, pz2_q;
  logic signed [ZW-1:0]  u3_q, v01_q, z01_q;

  logic signed [ZW-1:0]  u_q, v_q, z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hv_q  <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
      hv_q  <= {hv_q[1:0], hv_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: offsets and height product
      dx_q    <= DXW'(px_i) - DXW'(cfg_i.ox);
      dy_q    <= DXW'(py_i) - DXW'(cfg_i.oy);
      hprod_q <= h_i * HScale;
      // stage 2: rotation products and scaled height
      tz_q    <= TZW'(hprod_q >>> 8) + TZW'(cfg_i.hoff);
      pu0_q   <= dx_q * cfg_i.cy;
      pu1_q   <= dy_q * cfg_i.sy;
      pv0_q   <= dx_q * cfg_i.m10;
      pv1_q   <= dy_q * cfg_i.m11;
      pz0_q   <= dx_q * cfg_i.m20;
      pz1_q   <= dy_q * cfg_i.m21;
      // stage 3: height terms and first sums
      pv2_q   <= tz_q * cfg_i.sp;
      pz2_q   <= tz_q * cfg_i.cp;
      u3_q    <= ZW'(pu0_q) + ZW'(pu1_q);
      v01_q   <= ZW'(pv0_q) + ZW'(pv1_q);
      z01_q   <= ZW'(pz0_q) + ZW'(pz1_q);
      // stage 4: final sums
      u_q     <= u3_q;
      v_q     <= v01_q + ZW'(pv2_q);
      z_q     <= z01_q + ZW'(pz2_q);
    end
  end

  // height flag is sampled with the point and lines up with stage 4
  logic hv4_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hv4_q <= hv_q[2];
    end
  end

  assign valid_o = vld_q[3];
  assign hv_o    = hv4_q;
  assign u_o     = u_q;
  assign v_o     = v_q;
  assign z_o     = z_q;

endmodule

>>> hw/rtl/tppu_muldiv.sv
// ----------------------------------------------------------------------------
// tppu_muldiv: two lanes of floor(a * sf / d), capped at 2^40
// Split multiply over two stages, a cap check, then one quotient bit per
// stage of a restoring divider.
// ----------------------------------------------------------------------------
module tppu_muldiv
  import tppu_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  side_t         side_i,
  input  logic [AW-1:0] a_col_i,
  input  logic [AW-1:0] a_row_i,
  input  logic [AW-1:0] d_i,
  input  logic [31:0]   sf_i,
  output logic          valid_o,
  output side_t         side_o,
  output logic [QW:0]   q_col_o,
  output logic [QW:0]   q_row_o
);

  typedef struct packed {
    logic          ovf;
    logic [AW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t [1:0]   lane;
    side_t         side;
    logic [AW-1:0] d;
  } div_stage_t;

  function automatic lane_t div_step(lane_t l, logic [AW-1:0] d);
    logic [AW:0] r2;
    logic        ge;
    lane_t       n;
    r2    = {l.rem, l.low[QW-1]};
    ge    = (r2 >= {1'b0, d});
    n     = l;
    n.rem = ge ? AW'(r2 - {1'b0, d}) : r2[AW-1:0];
    n.low = {l.low[QW-2:0], 1'b0};
    n.quo = {l.quo[QW-2:0], ge};
    return n;
  endfunction

  logic [1:0] pre_vld_q;
  logic [QW:0] vld_q;

  logic [62:0]   lo_q [2];
  logic [61:0]   hi_q [2];
  logic [AW-1:0] d1_q, d2_q;
  side_t         side1_q, side2_q;
  logic [PW-1:0] p_q [2];

  logic [AW-1:0] a_in [2];
  div_stage_t    st_d [QW+1];
  div_stage_t    st_q [QW+1];

  assign a_in[0] = a_col_i;
  assign a_in[1] = a_row_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= '0;
      vld_q     <= '0;
    end else if (en_i) begin
      pre_vld_q <= {pre_vld_q[0], valid_i};
      vld_q     <= {vld_q[QW-1:0], pre_vld_q[1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 2; k++) begin
        lo_q[k] <= {32'b0, a_in[k][30:0]} * {31'b0, sf_i};
        hi_q[k] <= {32'b0, a_in[k][AW-1:31]} * {30'b0, sf_i};
        p_q[k]  <= PW'(lo_q[k]) + {hi_q[k], 31'b0};
      end
      d1_q    <= d_i;
      side1_q <= side_i;
      d2_q    <= d1_q;
      side2_q <= side1_q;
    end
  end

  // cap check and remainder seed: quotient reaches 2^40 exactly when the
  // product from bit 40 up is not below the divisor
  always_comb begin
    st_d[0].d    = d2_q;
    st_d[0].side = side2_q;
    for (int k = 0; k < 2; k++) begin
      st_d[0].lane[k].ovf = ({8'b0, p_q[k][PW-1:QW]} >= d2_q);
      st_d[0].lane[k].rem = {8'b0, p_q[k][PW-1:QW]};
      st_d[0].lane[k].low = p_q[k][QW-1:0];
      st_d[0].lane[k].quo = '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    always_comb begin
      st_d[j+1].d    = st_q[j].d;
      st_d[j+1].side = st_q[j].side;
      for (int k = 0; k < 2; k++) begin
        st_d[j+1].lane[k] = div_step(st_q[j].lane[k], st_q[j].d);
      end
    end
  end

  for (genvar j = 0; j <= QW; j++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j] <= st_d[j];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign side_o  = st_q[QW].side;
  assign q_col_o = st_q[QW].lane[0].ovf ? {1'b1, {QW{1'b0}}} : {1'b0, st_q[QW].lane[0].quo};
  assign q_row_o = st_q[QW].lane[1].ovf ? {1'b1, {QW{1'b0}}} : {1'b0, st_q[QW].lane[1].quo};

endmodule

>>> bench/terrain_perspective_projection_unit_test.sv
// ----------------------------------------------------------------------------
// terrain_perspective_projection_unit_test: self-checking bench
// Streams terrain points through the projector under several camera setups
// and compares every result against a bit-exact software projection.
// ----------------------------------------------------------------------------
module terrain_perspective_projection_unit_test;
  import tppu_pkg::*;

  localparam int ROWS = 512;
  localparam int COLS = 512;
  localparam int HSCALE = 512;
  localparam int LATENCY = 49;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic signed [31:0] row;
    logic signed [31:0] col;
    logic               vis;
  } pixel_t;

  // Camera setup copy, kept in step with every register write
  logic signed [15:0] cam_cy, cam_sy, cam_cp, cam_sp;
  logic signed [31:0] cam_ox, cam_oy, cam_hoff;
  logic [31:0]        cam_sf;

  function automatic longint floor_div_pow2(longint x, int s);
    return x >>> s;  // arithmetic shift floors
  endfunction

  // floor(a*b/d), capped at 2^40
  function automatic logic [63:0] scaled_quot(logic [63:0] a, logic [31:0] b, logic [63:0] d);
    logic [127:0] p;
    logic [127:0] q;
    p = {64'd0, a} * {96'd0, b};
    q = p / {64'd0, d};
    if (q >= (128'd1 << 40)) return 64'd1 << 40;
    return q[63:0];
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic pixel_t project_point(logic [31:0] px, logic [31:0] py, logic [31:0] h,
                                           logic ok);
    pixel_t r;
    longint cy, sy, cp, sp, dx, dy, tz, m10, m11, m20, m21, u, v, z, qc, qr;
    logic [63:0] au, av, az;
    cy = longint'(cam_cy); sy = longint'(cam_sy);
    cp = longint'(cam_cp); sp = longint'(cam_sp);
    dx = longint'($signed(px)) - longint'(cam_ox);
    dy = longint'($signed(py)) - longint'(cam_oy);
    tz = floor_div_pow2(HSCALE * longint'($signed(h)), 8) + longint'(cam_hoff);
    m10 = floor_div_pow2(-(cp * sy), 14);
    m11 = floor_div_pow2(cp * cy, 14);
    m20 = floor_div_pow2(sp * sy, 14);
    m21 = floor_div_pow2(-(sp * cy), 14);
    u = cy * dx + sy * dy;
    v = m10 * dx + m11 * dy + sp * tz;
    z = m20 * dx + m21 * dy + cp * tz;
    r = '0;
    if (ok && z <= -(64'sd1 <<< 22)) begin
      az = -z;
      au = (u < 0) ? -u : u;
      av = (v < 0) ? -v : v;
      qc = scaled_quot(au, cam_sf, az);
      qr = scaled_quot(av, cam_sf, az);
      if (u < 0) qc = -qc;
      if (v > 0) qr = -qr;
      r.col = 32'(clamp32(qc + (longint'(COLS) <<< 7)));
      r.row = 32'(clamp32(qr + (longint'(ROWS) <<< 7)));
      r.vis = 1'b1;
    end
    return r;
  endfunction

  class pixel_scoreboard;
    pixel_t pending[$];
    int     errors;
    int     checked;
    int     visible_seen;

    function void note_point(pixel_t p);
      pending.push_back(p);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result col=%0d row=%0d vis=%0b", $time, got.col, got.row,
                 got.vis);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.vis) visible_seen++;
      if (got.col !== want.col) begin
        $display("%0t: pixel_col expected %0d actual %0d", $time, want.col, got.col);
        errors++;
      end
      if (got.row !== want.row) begin
        $display("%0t: pixel_row expected %0d actual %0d", $time, want.row, got.row);
        errors++;
      end
      if (got.vis !== want.vis) begin
        $display("%0t: visible expected %0b actual %0b", $time, want.vis, got.vis);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // point_x, point_y, terrain_height
  logic [0:0]  s_axis_tuser = '0;   // height_valid
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // pixel_col, pixel_row
  logic [0:0]  m_axis_tuser;        // visible
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  pixel_scoreboard board = new();
  int cycles = 0;
  bit hold_sink = 1'b0;  // long receiver hold-off
  bit no_gaps = 1'b0;

  always #4 clk_i = ~clk_i;

  terrain_perspective_projection_unit i_dut (.*);

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("terrain_perspective_projection_unit_test: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, mostly short, a few long, none during the hold-off
  initial begin
    int wait_len;
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
      end else if (no_gaps || $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        wait_len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        m_axis_tready <= 1'b0;
        repeat (wait_len - 1) @(posedge clk_i);
      end
    end
  end

  // Sample results at the clock edge, before the registers update
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_pixel('{col: m_axis_tdata[31:0], row: m_axis_tdata[63:32],
                          vis: m_axis_tuser[0]});
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_COS_YAW:       cam_cy = value[15:0];
      CFG_SIN_YAW:       cam_sy = value[15:0];
      CFG_COS_PITCH:     cam_cp = value[15:0];
      CFG_SIN_PITCH:     cam_sp = value[15:0];
      CFG_OBSERVER_X:    cam_ox = value;
      CFG_OBSERVER_Y:    cam_oy = value;
      CFG_HEIGHT_OFFSET: cam_hoff = value;
      CFG_FOCAL_SCALE:   cam_sf = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offer one point; hold it until the transfer, then log the expectation
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] h, logic ok);
    int gap;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {h, py, px};
    s_axis_tuser  <= ok;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_point(project_point(px, py, h, ok));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // Trig angle pair in Q1.14, from a small table of exact-ish values
  task automatic set_camera(int yaw_pick, int pitch_pick);
    logic signed [15:0] c[8];
    logic signed [15:0] s[8];
    c = '{16384, 11585, 0, -11585, -16384, 14189, 8192, -16384};
    s = '{0, 11585, 16384, 11585, 0, -8192, -14189, 16384};
    write_reg(CFG_COS_YAW, 32'(c[yaw_pick]));
    write_reg(CFG_SIN_YAW, 32'(s[yaw_pick]));
    write_reg(CFG_COS_PITCH, 32'(c[pitch_pick]));
    write_reg(CFG_SIN_PITCH, 32'(s[pitch_pick]));
  endtask

  // Terrain points near the observer, scattered on all sides of it and in height
  task automatic send_scene_point;
    logic [31:0] px, py, h;
    px = cam_ox + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    py = cam_oy + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    h = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    send_point(px, py, h, $urandom_range(0, 7) != 0);
  endtask

  initial begin
    logic [31:0] ext[4];
    cam_cy = 16'sd16384; cam_sy = '0; cam_cp = 16'sd16384; cam_sp = '0;
    cam_ox = '0; cam_oy = '0; cam_hoff = '0; cam_sf = 32'd91776;
    ext = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset camera, extremes, invalid, behind, near edge of depth cutoff
    foreach (ext[i]) send_point(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], 1'b1);
    send_point(32'd0, 32'd0, -32'sd1000, 1'b0);    // invalid point
    send_point(32'd0, 32'd0, 32'sd1000, 1'b1);     // above the eye with level view
    drain();
    set_camera(0, 3);                              // pitched down
    write_reg(CFG_HEIGHT_OFFSET, -32'sd2560);
    send_point(32'd0, 32'd256, 32'd0, 1'b1);
    send_point(32'd0, 32'd0, 32'sd128, 1'b1);      // depth just at one meter
    send_point(32'd0, 32'd0, 32'sd127, 1'b1);
    send_point(32'd1, 32'd0, 32'd0, 1'b1);         // tiny depth, huge quotient
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    drain();
    write_reg(CFG_FOCAL_SCALE, 32'hFFFF_FFFF);
    write_reg(CFG_OBSERVER_X, 32'h7FFF_FFFF);
    write_reg(CFG_OBSERVER_Y, 32'h8000_0000);
    write_reg(CFG_HEIGHT_OFFSET, 32'h8000_0000);
    foreach (ext[i]) send_point(ext[i], ext[(i + 3) % 4], ext[i], 1'b1);
    drain();
    write_reg(CFG_COS_YAW, 32'h0000_8000);         // out-of-range trig values
    write_reg(CFG_SIN_PITCH, 32'h0001_7FFF);
    write_reg(CFG_FOCAL_SCALE, 32'd0);
    foreach (ext[i]) send_point(ext[(i + 1) % 4], ext[i], ext[(i + 3) % 4], 1'b1);
    drain();

    // Random phases over varied cameras; hold-off in the second phase fills the pipe
    for (int ph = 0; ph < 6; ph++) begin
      set_camera($urandom_range(0, 7), $urandom_range(1, 7));
      write_reg(CFG_OBSERVER_X, $urandom());
      write_reg(CFG_OBSERVER_Y, $urandom());
      write_reg(CFG_HEIGHT_OFFSET, $signed($urandom_range(0, 1 << 16)) - (1 << 16));
      write_reg(CFG_FOCAL_SCALE, (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(1, 1 << 20));
      no_gaps = (ph == 3);
      if (ph == 1) begin
        fork
          begin
            hold_sink = 1'b1;
            repeat (200) @(posedge clk_i);
            hold_sink = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_point($urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
        else
          send_scene_point();
      end
      drain();
    end
    no_gaps = 1'b0;

    $display("Checked %0d results, %0d visible, across level, pitched, saturating",
             board.checked, board.visible_seen);
    $display("and out-of-range camera setups with random stalls and a full-pipe hold-off.");
    if (board.errors == 0) begin
      $display("terrain_perspective_projection_unit_test: PASS");
    end else begin
      $display("terrain_perspective_projection_unit_test: FAIL");
    end
    $finish;
  end

endmodule
